[hdl/sfd_pkg.sv]
// shared constants and types for the sbus frame decoder
`timescale 1ns / 1ps
`default_nettype none
package sfd_pkg;

  localparam int FRAME_LEN    = 25;
  localparam int NUM_CHANNELS = 16;
  localparam int CHAN_BITS    = 11;
  localparam int DATA_BYTES   = 22;
  localparam int DATA_BITS    = DATA_BYTES * 8;
  localparam int FLAG_POS     = 23;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [7:0] HEADER_BYTE    = 8'h0F;
  localparam logic [7:0] END_CHECK_MASK = 8'hF0;
  localparam logic [7:0] LOST_BIT       = 8'h04;
  localparam logic [7:0] FAILSAFE_BIT   = 8'h08;

  typedef logic [$clog2(FRAME_LEN)-1:0] byte_count_t;
  typedef logic [$clog2(NUM_CHANNELS)-1:0] chan_idx_t;

  typedef struct packed {
    logic [DATA_BITS-1:0] data;
    logic                 lost;
    logic                 failsafe;
  } frame_t;

endpackage
`default_nettype wire

[hdl/sfd_front.sv]
// front end: header hunt, byte collection and end byte check
`timescale 1ns / 1ps
`default_nettype none
module sfd_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [7:0]      rx_byte,
  output logic                 push,
  output sfd_pkg::frame_t      push_frame,
  input  wire logic            q_full
);

  sfd_pkg::byte_count_t               byte_count;
  logic [sfd_pkg::DATA_BITS-1:0]      data;
  logic [7:0]                         flags;
  logic                               accept;
  logic                               at_end;

  assign at_end   = byte_count == sfd_pkg::byte_count_t'(sfd_pkg::FRAME_LEN - 1);
  // only the end byte can need queue room
  assign in_ready = !(at_end && q_full);
  assign accept   = in_valid && in_ready;
  assign push     = accept && at_end && ((rx_byte & sfd_pkg::END_CHECK_MASK) == 8'h00);

  assign push_frame.data     = data;
  assign push_frame.lost     = (flags & sfd_pkg::LOST_BIT) != 8'h00;
  assign push_frame.failsafe = (flags & sfd_pkg::FAILSAFE_BIT) != 8'h00;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
    end else if (accept) begin
      if (byte_count == '0) begin
        if (rx_byte == sfd_pkg::HEADER_BYTE) begin
          byte_count <= sfd_pkg::byte_count_t'(1);
        end
      end else if (at_end) begin
        byte_count <= '0;
      end else begin
        byte_count <= byte_count + sfd_pkg::byte_count_t'(1);
      end
    end
  end

  // data bytes shift in from the top, so byte 1 ends up in the low bits
  always_ff @(posedge clk) begin
    if (accept && byte_count != '0) begin
      if (byte_count <= sfd_pkg::byte_count_t'(sfd_pkg::DATA_BYTES)) begin
        data <= {rx_byte, data[sfd_pkg::DATA_BITS-1:8]};
      end
      if (byte_count == sfd_pkg::byte_count_t'(sfd_pkg::FLAG_POS)) begin
        flags <= rx_byte;
      end
    end
  end

endmodule
`default_nettype wire

[hdl/sfd_queue.sv]
// small queue of decoded-ready frames between front and back end
`timescale 1ns / 1ps
`default_nettype none
module sfd_queue #(
  parameter int Depth = sfd_pkg::QUEUE_DEPTH
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire sfd_pkg::frame_t push_frame,
  output logic                 full,
  input  wire logic            pop,
  output logic                 not_empty,
  output sfd_pkg::frame_t      head
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  sfd_pkg::frame_t   entries [Depth];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CntW-1:0]   count;

  assign full      = count == CntW'(Depth);
  assign not_empty = count != '0;
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_frame;
    end
  end

endmodule
`default_nettype wire

[hdl/sfd_back.sv]
// back end: unpacks one channel per cycle into the output register unless out_ready stalls it
`timescale 1ns / 1ps
`default_nettype none
module sfd_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_not_empty,
  input  wire sfd_pkg::frame_t head,
  output logic                 pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [3:0]           channel_index,
  output logic [10:0]          channel_value,
  output logic                 frame_lost,
  output logic                 failsafe_flag,
  output logic                 last_channel
);

  sfd_pkg::chan_idx_t ch_cnt;
  logic               advance;
  logic               is_last;

  assign advance = !out_valid || out_ready;
  assign is_last = ch_cnt == sfd_pkg::chan_idx_t'(sfd_pkg::NUM_CHANNELS - 1);
  assign pop     = advance && q_not_empty && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      ch_cnt    <= '0;
    end else if (advance) begin
      out_valid <= q_not_empty;
      if (q_not_empty) begin
        ch_cnt <= ch_cnt + sfd_pkg::chan_idx_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && q_not_empty) begin
      channel_index <= ch_cnt;
      channel_value <= head.data[ch_cnt * sfd_pkg::CHAN_BITS +: sfd_pkg::CHAN_BITS];
      frame_lost    <= head.lost;
      failsafe_flag <= head.failsafe;
      last_channel  <= is_last;
    end
  end

endmodule
`default_nettype wire

[hdl/sbus_frame_decoder.sv]
// top level of the sbus frame decoder
// Takes one received byte per cycle on the in channel while in_ready is high.
// Bytes are dropped until a 0x0F header opens a frame; 25 bytes make a frame.
// If the end byte has a zero upper nibble, the frame goes into a two-frame
// queue and the back end sends 16 words, channels 0 to 15, one per cycle
// unless out_ready stalls it, each with the frame lost and failsafe flags
// and a last mark on channel 15. in_ready drops only on the end byte of a
// frame while the queue is full; the back end uses a single channel unpacker.
`timescale 1ns / 1ps
`default_nettype none
module sbus_frame_decoder #(
  parameter int QueueDepth = sfd_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       channel_index,
  output logic [10:0]      channel_value,
  output logic             frame_lost,
  output logic             failsafe_flag,
  output logic             last_channel
);

  logic            push;
  sfd_pkg::frame_t push_frame;
  logic            q_full;
  logic            pop;
  logic            q_not_empty;
  sfd_pkg::frame_t head;

  sfd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .push       (push),
    .push_frame (push_frame),
    .q_full     (q_full)
  );

  sfd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_frame (push_frame),
    .full       (q_full),
    .pop        (pop),
    .not_empty  (q_not_empty),
    .head       (head)
  );

  sfd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_not_empty   (q_not_empty),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .channel_index (channel_index),
    .channel_value (channel_value),
    .frame_lost    (frame_lost),
    .failsafe_flag (failsafe_flag),
    .last_channel  (last_channel)
  );

endmodule
`default_nettype wire
